// File: design/aea_pkg.sv
package aea_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned BytesW  = 16;
  localparam int unsigned DimCntW = 5;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASE_ADDRESS    = 2'd0,
    CFG_ELEMENT_BYTES   = 2'd1,
    CFG_DIMENSION_COUNT = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  typedef struct packed {
    logic                    mode;
    logic [SlotW-1:0]        dim_slot;
    logic signed [DataW-1:0] lower_bound;
    logic signed [DataW-1:0] upper_bound;
    logic signed [DataW-1:0] index_value;
  } in_req_t;

  typedef struct packed {
    logic signed [DataW-1:0] address;
  } out_rsp_t;

  typedef struct packed {
    logic [DataW-1:0] lower;
    logic [DataW-1:0] upper;
  } bounds_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

// File: design/aea_in_if.sv
interface aea_in_if import aea_pkg::*; ();
  logic    valid;
  logic    ready;
  in_req_t req;

  modport source (output valid, output req, input ready);
  modport sink (input valid, input req, output ready);
endinterface

// File: design/aea_out_if.sv
interface aea_out_if import aea_pkg::*; ();
  logic     valid;
  logic     ready;
  out_rsp_t rsp;

  modport source (output valid, output rsp, input ready);
  modport sink (input valid, input rsp, output ready);
endinterface

// File: design/array_element_address_top.sv
// Byte address of an element of a row-major multidimensional array whose dimensions
// have arbitrary lower and upper bounds. A request with mode 0 loads the bounds of
// one dimension into a bounds RAM. A request with mode 1 carries the next index of a
// query, first dimension first; it reads the bounds RAM, forms the extent and
// multiplies it into the running offset, so in_i.ready returns only after the read,
// multiply and accumulate states. The last index of a query goes on through a scale
// state and an output state, to scale by the element size and add the base address
// into the output register, which holds the result while the next request is taken;
// if an earlier result still waits there, the last index waits until it is taken. The
// bounds RAM read is registered. All arithmetic wraps modulo 2^32 and no bounds check
// is made. Write the configuration only while no query is in progress.
module array_element_address_top import aea_pkg::*; #(
  parameter int unsigned MAX_DIMS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  aea_in_if.sink             in_i,
  aea_out_if.source          out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_wdata_i
);

  localparam int unsigned AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  logic [DataW-1:0]   base_address_q;
  logic [BytesW-1:0]  element_bytes_q;
  logic [DimCntW-1:0] dimension_count_q;

  mem_ctl_t      mem_ctl;
  logic [AW-1:0] mem_waddr;
  bounds_t       mem_wdata;
  logic [AW-1:0] mem_raddr;
  bounds_t       mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_address_q    <= '0;
      element_bytes_q   <= BytesW'(1);
      dimension_count_q <= DimCntW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE_ADDRESS:    base_address_q    <= cfg_wdata_i;
        CFG_ELEMENT_BYTES:   element_bytes_q   <= cfg_wdata_i[BytesW-1:0];
        CFG_DIMENSION_COUNT: dimension_count_q <= cfg_wdata_i[DimCntW-1:0];
        default: begin
        end
      endcase
    end
  end

  aea_bounds_ram #(
    .MAX_DIMS (MAX_DIMS)
  ) u_bounds_ram (
    .clk_i     (clk_i),
    .mem_ctl_i (mem_ctl),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_i   (mem_raddr),
    .rdata_o   (mem_rdata)
  );

  aea_offset_unit #(
    .MAX_DIMS (MAX_DIMS)
  ) u_offset_unit (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_i              (in_i),
    .out_o             (out_o),
    .base_address_i    (base_address_q),
    .element_bytes_i   (element_bytes_q),
    .dimension_count_i (dimension_count_q),
    .mem_ctl_o         (mem_ctl),
    .mem_waddr_o       (mem_waddr),
    .mem_wdata_o       (mem_wdata),
    .mem_raddr_o       (mem_raddr),
    .mem_rdata_i       (mem_rdata)
  );

endmodule

// File: design/aea_bounds_ram.sv
module aea_bounds_ram import aea_pkg::*; #(
  parameter int unsigned MAX_DIMS = 16,
  localparam int unsigned AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
  input  logic          clk_i,
  input  mem_ctl_t      mem_ctl_i,
  input  logic [AW-1:0] waddr_i,
  input  bounds_t       wdata_i,
  input  logic [AW-1:0] raddr_i,
  output bounds_t       rdata_o
);

  bounds_t mem_q [MAX_DIMS];
  bounds_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (mem_ctl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/aea_offset_unit.sv
module aea_offset_unit import aea_pkg::*; #(
  parameter int unsigned MAX_DIMS = 16,
  localparam int unsigned AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  aea_in_if.sink             in_i,
  aea_out_if.source          out_o,
  input  logic [DataW-1:0]   base_address_i,
  input  logic [BytesW-1:0]  element_bytes_i,
  input  logic [DimCntW-1:0] dimension_count_i,
  output mem_ctl_t           mem_ctl_o,
  output logic [AW-1:0]      mem_waddr_o,
  output bounds_t            mem_wdata_o,
  output logic [AW-1:0]      mem_raddr_o,
  input  bounds_t            mem_rdata_i
);

  localparam int unsigned CW =
      ($clog2(MAX_DIMS + 1) > DimCntW) ? $clog2(MAX_DIMS + 1) : DimCntW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_MUL,
    S_ACC,
    S_SCL,
    S_OUT
  } state_e;

  state_e           state_q;
  logic [AW-1:0]    pos_q;
  logic [DataW-1:0] acc_q;
  logic [DataW-1:0] acc_d;
  logic             out_valid_q;
  logic [DataW-1:0] addr_q;
  logic [DataW-1:0] idx_q;
  logic [DataW-1:0] diff_q;
  logic [DataW-1:0] extent_q;
  logic [DataW-1:0] prod_q;
  logic [DataW-1:0] scaled_q;

  logic          in_acc;
  logic          load_acc;
  logic          query_acc;
  logic          slot_ok;
  logic          last_dim;
  logic [CW-1:0] cnt_ext;
  logic [CW-1:0] n_eff;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign load_acc   = in_acc && (in_i.req.mode == MODE_LOAD);
  assign query_acc  = in_acc && (in_i.req.mode == MODE_QUERY);
  assign slot_ok    = (CW'(in_i.req.dim_slot) < CW'(MAX_DIMS));

  assign mem_ctl_o.we = load_acc && slot_ok;
  assign mem_ctl_o.re = query_acc;
  assign mem_waddr_o  = AW'(in_i.req.dim_slot);
  assign mem_wdata_o  = '{lower: in_i.req.lower_bound, upper: in_i.req.upper_bound};
  assign mem_raddr_o  = pos_q;

  // clamp count into 1..MAX_DIMS
  always_comb begin
    cnt_ext = CW'(dimension_count_i);
    if (cnt_ext == '0) begin
      n_eff = CW'(1);
    end else if (cnt_ext > CW'(MAX_DIMS)) begin
      n_eff = CW'(MAX_DIMS);
    end else begin
      n_eff = cnt_ext;
    end
  end

  assign last_dim = (CW'(pos_q) + CW'(1)) >= n_eff;
  assign acc_d    = prod_q + diff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      addr_q      <= '0;
    end else begin
      if (out_o.valid && out_o.ready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (query_acc) begin
            state_q <= S_RD;
          end
        end
        S_RD: begin
          state_q <= S_MUL;
        end
        S_MUL: begin
          state_q <= S_ACC;
        end
        S_ACC: begin
          acc_q <= acc_d;
          if (last_dim) begin
            pos_q   <= '0;
            state_q <= S_SCL;
          end else begin
            pos_q   <= pos_q + AW'(1);
            state_q <= S_IDLE;
          end
        end
        S_SCL: begin
          acc_q   <= '0;
          state_q <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            addr_q      <= base_address_i + scaled_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      idx_q <= in_i.req.index_value;
    end
    if (state_q == S_RD) begin
      extent_q <= mem_rdata_i.upper - mem_rdata_i.lower + DataW'(1);
      diff_q   <= idx_q - mem_rdata_i.lower;
    end
    if (state_q == S_MUL) begin
      prod_q <= acc_q * extent_q;
    end
    if (state_q == S_SCL) begin
      scaled_q <= DataW'(element_bytes_i) * acc_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.rsp.address = addr_q;

  a_read_follows_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_acc |=> (state_q == S_RD))
    else $error("query request did not start a bounds read");

  a_acc_cleared_at_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> ((acc_q == '0) && (pos_q == '0)))
    else $error("offset state not cleared before the result");

  a_result_from_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("result raised outside the output step");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(pos_q) < CW'(MAX_DIMS))
    else $error("dimension position beyond the bounds table");

endmodule
